// ===== hw/rtl/tiex_pkg.sv =====
// shared types, constants and helpers for the toy isa execute unit
package tiex_pkg;

  localparam int RegCount   = 16;
  localparam int ArrayDepth = 32;
  localparam int PcWidth    = 10;
  localparam int RegIdxW    = 5;
  localparam int ArrAddrW   = 7;
  localparam int ArrWords   = 128;

  typedef enum logic [4:0] {
    OP_ADDI = 5'd0,  OP_SUBI = 5'd1,  OP_MULI = 5'd2,  OP_DIVI = 5'd3,
    OP_MODI = 5'd4,  OP_AND  = 5'd5,  OP_OR   = 5'd6,  OP_NOT  = 5'd7,
    OP_XOR  = 5'd8,  OP_ADD  = 5'd9,  OP_SUB  = 5'd10, OP_MUL  = 5'd11,
    OP_DIV  = 5'd12, OP_MOD  = 5'd13, OP_CMPI = 5'd14, OP_MOVI = 5'd15,
    OP_MOV  = 5'd16, OP_CMP  = 5'd17, OP_IN   = 5'd18, OP_OUT  = 5'd19,
    OP_INC  = 5'd20, OP_DEC  = 5'd21, OP_JMP  = 5'd22, OP_JEQ  = 5'd23,
    OP_JLT  = 5'd24, OP_JGT  = 5'd25, OP_HLT  = 5'd26, OP_ARRD = 5'd27,
    OP_ARRI = 5'd28, OP_ARRC = 5'd29, OP_RSV0 = 5'd30, OP_RSV1 = 5'd31
  } op_t;

  localparam logic [3:0] ALU_ADD = 4'b0000;
  localparam logic [3:0] ALU_SUB = 4'b0001;
  localparam logic [3:0] ALU_MUL = 4'b0010;
  localparam logic [3:0] ALU_DIV = 4'b0011;
  localparam logic [3:0] ALU_INC = 4'b0100;
  localparam logic [3:0] ALU_DEC = 4'b0101;
  localparam logic [3:0] ALU_AND = 4'b0110;
  localparam logic [3:0] ALU_OR  = 4'b0111;
  localparam logic [3:0] ALU_XOR = 4'b1000;
  localparam logic [3:0] ALU_NOT = 4'b1001;
  localparam logic [3:0] ALU_MOD = 4'b1010;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_EQ   = 2'd1;
  localparam logic [1:0] ST_GT   = 2'd2;
  localparam logic [1:0] ST_LT   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } stat_t;

  function automatic logic [1:0] compare3(logic [31:0] a, logic [31:0] b);
    if (a == b) return ST_EQ;
    return ($signed(a) > $signed(b)) ? ST_GT : ST_LT;
  endfunction

endpackage

// ===== hw/rtl/tiex_ram.sv =====
// generic single-port ram with registered read
module tiex_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/tiex_ctrl.sv =====
// controller state machine for the execute unit
module tiex_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           res_valid,
  input  logic           res_ready,
  input  tiex_pkg::stat_t stat,
  output tiex_pkg::cmd_t  cmd
);
  import tiex_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.need_div ? S_DIV : S_FIN;
      S_DIV:  if (stat.div_done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: cmd.exec = 1'b0;
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.div_start = stat.need_div;
      end
      // stop stepping once all 32 quotient bits are in
      S_DIV:  cmd.div_step = !stat.div_done;
      S_FIN:  cmd.finish = 1'b1;
      S_OUT:  res_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/tiex_dpath.sv =====
// datapath: register file, arrays, alu, serial divider, result registers
module tiex_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tiex_pkg::cmd_t                cmd,
  output tiex_pkg::stat_t               stat,
  input  logic [4:0]                    in_operation,
  input  logic [31:0]                   in_instr_word,
  input  logic signed [31:0]            in_input_value,
  output logic [9:0]                    next_pc,
  output logic [1:0]                    status_flag,
  output logic                          zero_flag,
  output logic                          alu_valid,
  output logic [3:0]                    alu_control,
  output logic                          outv,
  output logic signed [31:0]            out_value
);
  import tiex_pkg::*;

  logic [31:0] regs_r [RegCount];
  logic [1:0]  cmp_r;
  logic [PcWidth-1:0] pc_r;
  op_t         op_r;
  logic [31:0] w_r, inval_r;

  logic [4:0] f19, f14, f9, f4;
  assign f19 = w_r[19:15];
  assign f14 = w_r[14:10];
  assign f9  = w_r[9:5];
  assign f4  = w_r[4:0];

  function automatic logic [31:0] rd(logic [31:0] r [RegCount], logic [4:0] i);
    if (32'(i) < RegCount) return r[i[$clog2(RegCount)-1:0]];
    return 32'd0;
  endfunction

  // array ram
  logic arr_hit, arr_we;
  logic [ArrAddrW-1:0] arr_addr;
  logic [31:0] arr_q;
  assign arr_hit = (f14 >= 5'd16) && (f14 <= 5'd19) && (32'(f9) < ArrayDepth);
  assign arr_addr = {f14[1:0], f9};
  assign arr_we = cmd.exec && arr_hit && (op_r == OP_ARRI);

  tiex_ram #(.Width(32), .Depth(ArrWords)) u_arr (
    .clk(clk), .we(arr_we), .addr(arr_addr), .wdata(rd(regs_r, f4)), .rdata(arr_q)
  );

  // operands
  logic [31:0] a, b;
  logic imm_form, reg_form, is_div, is_mod;
  assign imm_form = (op_r <= OP_MODI);
  assign reg_form = (op_r >= OP_AND) && (op_r <= OP_MOD) && (op_r != OP_NOT);
  always_comb begin
    a = 32'd0;
    b = 32'd0;
    if (imm_form) begin
      a = rd(regs_r, f14);
      b = {22'd0, w_r[9:0]};
    end else if (reg_form) begin
      a = rd(regs_r, f9);
      b = rd(regs_r, f4);
    end
  end
  assign is_div = (op_r == OP_DIVI) || (op_r == OP_DIV);
  assign is_mod = (op_r == OP_MODI) || (op_r == OP_MOD);
  assign stat.need_div = (is_div || is_mod) && (b != 32'd0);

  // restoring divider, one bit per cycle
  logic [31:0] dq_r, drem_r, dden_r;
  logic [5:0]  dcnt_r;
  logic        dnq_r, dnr_r;
  logic [32:0] trial;
  assign trial = {drem_r, dq_r[31]} - {1'b0, dden_r};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r   <= a[31] ? 32'd0 - a : a;
      dden_r <= b[31] ? 32'd0 - b : b;
      drem_r <= 32'd0;
      dcnt_r <= 6'd0;
      dnq_r  <= a[31] ^ b[31];
      dnr_r  <= a[31];
    end else if (cmd.div_step) begin
      if (!trial[32]) begin
        drem_r <= trial[31:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= {drem_r[30:0], dq_r[31]};
        dq_r   <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 6'd1;
    end
  end
  assign stat.div_done = (dcnt_r == 6'd32);

  // main compute, registered in exec
  logic [31:0] mul_r;
  logic [31:0] val_r, val_c;
  logic [4:0]  dst_r, dst_c;
  logic        wr_r, wr_c, alu_r, alu_c, outv_c;
  logic [3:0]  code_r, code_c;
  logic [31:0] outval_c;
  logic [1:0]  cmp_c;
  logic [PcWidth-1:0] next_c, next_r, tgt;
  assign tgt = w_r[PcWidth-1:0] & PcWidth'({10{1'b1}});

  always_comb begin
    val_c = 32'd0; dst_c = 5'd0; wr_c = 1'b0; alu_c = imm_form || reg_form;
    code_c = ALU_ADD; outv_c = 1'b0; outval_c = 32'd0; cmp_c = cmp_r;
    next_c = pc_r + PcWidth'(1);
    if (imm_form) begin dst_c = f19; wr_c = 1'b1; end
    else if (reg_form) begin dst_c = f14; wr_c = 1'b1; end
    case (op_r)
      OP_ADDI, OP_ADD: begin val_c = a + b; code_c = ALU_ADD; end
      OP_SUBI, OP_SUB: begin val_c = a - b; code_c = ALU_SUB; end
      OP_MULI, OP_MUL: begin val_c = 32'd0; code_c = ALU_MUL; end
      OP_DIVI, OP_DIV: begin val_c = rd(regs_r, dst_c); code_c = ALU_DIV; end
      OP_MODI, OP_MOD: begin val_c = rd(regs_r, dst_c); code_c = ALU_MOD; end
      OP_AND: begin val_c = a & b; code_c = ALU_AND; end
      OP_OR:  begin val_c = a | b; code_c = ALU_OR; end
      OP_XOR: begin val_c = a ^ b; code_c = ALU_XOR; end
      OP_NOT: begin
        dst_c = f9; val_c = ~rd(regs_r, f4); wr_c = 1'b1; alu_c = 1'b1; code_c = ALU_NOT;
      end
      OP_CMPI: cmp_c = compare3(rd(regs_r, f14), {22'd0, w_r[9:0]});
      OP_MOVI: begin dst_c = f14; val_c = {22'd0, w_r[9:0]}; wr_c = 1'b1; end
      OP_MOV:  begin dst_c = f9; val_c = rd(regs_r, f4); wr_c = 1'b1; end
      OP_CMP:  cmp_c = compare3(rd(regs_r, f9), rd(regs_r, f4));
      OP_IN:   begin dst_c = f4; val_c = inval_r; wr_c = 1'b1; end
      OP_OUT:  begin outv_c = 1'b1; outval_c = rd(regs_r, f4); end
      OP_INC: begin
        dst_c = f4; val_c = rd(regs_r, f4) + 32'd1; wr_c = 1'b1; alu_c = 1'b1; code_c = ALU_INC;
      end
      OP_DEC: begin
        dst_c = f4; val_c = rd(regs_r, f4) - 32'd1; wr_c = 1'b1; alu_c = 1'b1; code_c = ALU_DEC;
      end
      OP_JMP: next_c = tgt;
      OP_JEQ: if (cmp_r == ST_EQ) next_c = tgt;
      OP_JLT: if (cmp_r == ST_LT) next_c = tgt;
      OP_JGT: if (cmp_r == ST_GT) next_c = tgt;
      OP_ARRC: if (arr_hit) cmp_c = compare3(arr_q, rd(regs_r, f4));
      default: ;
    endcase
  end

  logic mul_sel_r, div_sel_r;
  logic [31:0] final_val;
  always_comb begin
    final_val = val_r;
    if (mul_sel_r) final_val = mul_r;
    else if (div_sel_r) begin
      if (code_r == ALU_DIV) final_val = dnq_r ? 32'd0 - dq_r : dq_r;
      else final_val = dnr_r ? 32'd0 - drem_r : drem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      w_r     <= in_instr_word;
      inval_r <= in_input_value;
    end
    if (cmd.exec) begin
      mul_r     <= a * b;
      mul_sel_r <= (op_r == OP_MULI) || (op_r == OP_MUL);
      div_sel_r <= stat.need_div;
      val_r <= val_c; dst_r <= dst_c; wr_r <= wr_c; alu_r <= alu_c;
      code_r <= code_c; next_r <= next_c;
      outv <= outv_c; out_value <= outval_c;
    end
    if (cmd.finish) begin
      next_pc     <= 10'(next_r);
      zero_flag   <= wr_r && (final_val == 32'd0);
      alu_valid   <= alu_r;
      alu_control <= alu_r ? code_r : 4'd0;
      status_flag <= cmp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++) regs_r[i] <= 32'd0;
      cmp_r <= ST_NONE;
      pc_r  <= '0;
    end else begin
      if (cmd.exec) begin
        cmp_r <= cmp_c;
        pc_r  <= next_c;
      end
      if (cmd.finish && wr_r && (32'(dst_r) < RegCount))
        regs_r[dst_r[$clog2(RegCount)-1:0]] <= final_val;
    end
  end
endmodule

// ===== hw/rtl/toy_isa_execute_unit.sv =====
// top level of the toy isa execute unit
// Executes one decoded instruction per input transaction against a 16-entry
// register file, four 32-entry arrays held in a ram, a compare status and a
// program counter. Input channel: in_operation, in_instr_word and
// in_input_value under in_valid/in_ready. Result channel: out_next_pc,
// out_status_flag, out_zero_flag, out_alu_valid, out_alu_control,
// out_out_valid and out_out_value under out_valid/out_ready.
// One instruction is in flight at a time. After acceptance the controller
// steps through read, execute and finish states before the result is valid,
// with a divide state after execute for a divide or modulo by a nonzero
// value, where a restoring divider produces one quotient bit per cycle.
// The next input is accepted only in idle, entered once the result is taken.
// A stalled receiver holds the result and the block accepts nothing more.
// Reset clears registers, compare status and program counter; the array
// contents are not cleared and must be written before they are compared.
module toy_isa_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         in_operation,
  input  logic [31:0]        in_instr_word,
  input  logic signed [31:0] in_input_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_next_pc,
  output logic [1:0]         out_status_flag,
  output logic               out_zero_flag,
  output logic               out_alu_valid,
  output logic [3:0]         out_alu_control,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value
);
  import tiex_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tiex_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .res_valid(out_valid), .res_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  tiex_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_operation(in_operation), .in_instr_word(in_instr_word),
    .in_input_value(in_input_value),
    .next_pc(out_next_pc), .status_flag(out_status_flag), .zero_flag(out_zero_flag),
    .alu_valid(out_alu_valid), .alu_control(out_alu_control),
    .outv(out_out_valid), .out_value(out_out_value)
  );
endmodule
